FILE: rtl/core/smbms_pkg.sv
package smbms_pkg;

    localparam int MAX_RES     = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [1:0] {
        FUNC_REQ   = 2'd0,
        FUNC_WDATA = 2'd1,
        FUNC_EVENT = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        REQ_SEND_BYTE   = 2'd0,
        REQ_BLOCK_WRITE = 2'd1,
        REQ_BLOCK_READ  = 2'd2,
        REQ_ALERT       = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        BUS_OK    = 2'd0,
        BUS_NACK  = 2'd1,
        BUS_ARB   = 2'd2,
        BUS_ERROR = 2'd3
    } bus_result_t;

    typedef enum logic [2:0] {
        OK_ACTION = 3'd0,
        OK_RXBYTE = 3'd1,
        OK_DONE   = 3'd2,
        OK_WANT   = 3'd3,
        OK_COUNT  = 3'd4
    } out_kind_t;

    typedef enum logic [2:0] {
        ACT_START   = 3'd0,
        ACT_SEND    = 3'd1,
        ACT_RX_ACK  = 3'd2,
        ACT_RX_NACK = 3'd3,
        ACT_STOP    = 3'd4
    } bus_action_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_NACK     = 3'd1,
        ST_ARB_LOST = 3'd2,
        ST_BUS_ERR  = 3'd3,
        ST_NO_ALERT = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START_W = 4'd1,
        PH_ADDR_W  = 4'd2,
        PH_CMD     = 4'd3,
        PH_COUNT   = 4'd4,
        PH_WANT    = 4'd5,
        PH_DATA    = 4'd6,
        PH_RSTART  = 4'd7,
        PH_ADDR_R  = 4'd8,
        PH_RXCOUNT = 4'd9,
        PH_RXDATA  = 4'd10,
        PH_A_START = 4'd11,
        PH_A_ADDR  = 4'd12,
        PH_A_RX    = 4'd13
    } phase_t;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] kind;
        logic [6:0] target_addr;
        logic [7:0] first_byte;
        logic [7:0] write_length;
        logic [7:0] data_byte;
        logic [1:0] bus_result;
    } in_item_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] op_kind;
        logic [6:0] saved_addr;
        logic [7:0] saved_command;
        logic [7:0] byte_total;
        logic [7:0] bytes_done;
    } seq_state_t;

    typedef struct packed {
        out_kind_t   out_kind;
        bus_action_t bus_action;
        logic [7:0]  out_byte;
        status_t     status;
        logic        last;
    } result_t;

    typedef result_t [MAX_RES-1:0] res_vec_t;

endpackage

FILE: rtl/core/smbms_step.sv
module smbms_step (
    input  smbms_pkg::in_item_t   item,
    input  smbms_pkg::seq_state_t state,
    input  logic [6:0]            alert_addr,
    output smbms_pkg::seq_state_t state_next,
    output smbms_pkg::res_vec_t   res,
    output logic [1:0]            res_count
);
    import smbms_pkg::*;

    function automatic result_t mk(out_kind_t k, bus_action_t a, logic [7:0] b, status_t s);
        result_t r;
        r.out_kind   = k;
        r.bus_action = a;
        r.out_byte   = b;
        r.status     = s;
        r.last       = 1'b0;
        return r;
    endfunction

    logic       is_rx;
    logic [7:0] done_inc;
    logic [8:0] done_inc2;
    status_t    err_st;
    res_vec_t   r;
    logic [1:0] n;

    always_comb
    begin
        state_next = state;
        r          = '0;
        n          = 2'd0;
        is_rx      = (state.phase == PH_RXCOUNT) || (state.phase == PH_RXDATA) ||
                     (state.phase == PH_A_RX);
        done_inc   = state.bytes_done + 8'd1;
        done_inc2  = {1'b0, done_inc} + 9'd1;
        err_st     = status_t'({1'b0, item.bus_result});
        if (((state.phase == PH_A_START) || (state.phase == PH_A_ADDR)) &&
            (item.bus_result == BUS_NACK))
        begin
            err_st = ST_NO_ALERT;
        end

        case (item.func)
            FUNC_REQ:
            begin
                if (state.phase == PH_IDLE)
                begin
                    state_next.op_kind       = item.kind;
                    state_next.saved_command = item.first_byte;
                    state_next.byte_total    = (item.kind == REQ_BLOCK_WRITE) ?
                                               item.write_length : 8'd0;
                    state_next.bytes_done    = 8'd0;
                    if (item.kind == REQ_ALERT)
                    begin
                        state_next.saved_addr = alert_addr;
                        state_next.phase      = PH_A_START;
                    end
                    else
                    begin
                        state_next.saved_addr = item.target_addr;
                        state_next.phase      = PH_START_W;
                    end
                    r[0] = mk(OK_ACTION, ACT_START, 8'd0, ST_NONE);
                    n    = 2'd1;
                end
            end
            FUNC_WDATA:
            begin
                if (state.phase == PH_WANT)
                begin
                    state_next.phase = PH_DATA;
                    r[0] = mk(OK_ACTION, ACT_SEND, item.data_byte, ST_NONE);
                    n    = 2'd1;
                end
            end
            FUNC_EVENT:
            begin
                if (state.phase != PH_IDLE && state.phase != PH_WANT)
                begin
                    if (!is_rx && item.bus_result != BUS_OK)
                    begin
                        // abort: stop, then done with the error status
                        r[0] = mk(OK_ACTION, ACT_STOP, 8'd0, ST_NONE);
                        r[1] = mk(OK_DONE, ACT_START, 8'd0, err_st);
                        n    = 2'd2;
                        state_next.phase = PH_IDLE;
                    end
                    else
                    begin
                        case (state.phase)
                            PH_START_W:
                            begin
                                state_next.phase = PH_ADDR_W;
                                r[0] = mk(OK_ACTION, ACT_SEND, {state.saved_addr, 1'b0}, ST_NONE);
                                n    = 2'd1;
                            end
                            PH_ADDR_W:
                            begin
                                state_next.phase = PH_CMD;
                                r[0] = mk(OK_ACTION, ACT_SEND, state.saved_command, ST_NONE);
                                n    = 2'd1;
                            end
                            PH_CMD:
                            begin
                                if (state.op_kind == REQ_BLOCK_WRITE)
                                begin
                                    state_next.phase = PH_COUNT;
                                    r[0] = mk(OK_ACTION, ACT_SEND, state.byte_total, ST_NONE);
                                    n    = 2'd1;
                                end
                                else if (state.op_kind == REQ_BLOCK_READ)
                                begin
                                    state_next.phase = PH_RSTART;
                                    r[0] = mk(OK_ACTION, ACT_START, 8'd0, ST_NONE);
                                    n    = 2'd1;
                                end
                                else
                                begin
                                    r[0] = mk(OK_ACTION, ACT_STOP, 8'd0, ST_NONE);
                                    r[1] = mk(OK_DONE, ACT_START, 8'd0, ST_NONE);
                                    n    = 2'd2;
                                    state_next.phase = PH_IDLE;
                                end
                            end
                            PH_COUNT, PH_DATA:
                            begin
                                if (state.phase == PH_DATA)
                                begin
                                    state_next.bytes_done = done_inc;
                                end
                                if (((state.phase == PH_DATA) ? done_inc : state.bytes_done)
                                    == state.byte_total)
                                begin
                                    r[0] = mk(OK_ACTION, ACT_STOP, 8'd0, ST_NONE);
                                    r[1] = mk(OK_DONE, ACT_START, 8'd0, ST_NONE);
                                    n    = 2'd2;
                                    state_next.phase = PH_IDLE;
                                end
                                else
                                begin
                                    state_next.phase = PH_WANT;
                                    r[0] = mk(OK_WANT, ACT_START, 8'd0, ST_NONE);
                                    n    = 2'd1;
                                end
                            end
                            PH_RSTART, PH_A_START:
                            begin
                                state_next.phase = (state.phase == PH_RSTART) ?
                                                   PH_ADDR_R : PH_A_ADDR;
                                r[0] = mk(OK_ACTION, ACT_SEND, {state.saved_addr, 1'b1}, ST_NONE);
                                n    = 2'd1;
                            end
                            PH_ADDR_R:
                            begin
                                state_next.phase = PH_RXCOUNT;
                                r[0] = mk(OK_ACTION, ACT_RX_ACK, 8'd0, ST_NONE);
                                n    = 2'd1;
                            end
                            PH_A_ADDR:
                            begin
                                state_next.phase = PH_A_RX;
                                r[0] = mk(OK_ACTION, ACT_RX_NACK, 8'd0, ST_NONE);
                                n    = 2'd1;
                            end
                            PH_RXCOUNT:
                            begin
                                state_next.byte_total = item.data_byte;
                                state_next.bytes_done = 8'd0;
                                r[0] = mk(OK_COUNT, ACT_START, item.data_byte, ST_NONE);
                                if (item.data_byte == 8'd0)
                                begin
                                    r[1] = mk(OK_ACTION, ACT_STOP, 8'd0, ST_NONE);
                                    r[2] = mk(OK_DONE, ACT_START, 8'd0, ST_NONE);
                                    n    = 2'd3;
                                    state_next.phase = PH_IDLE;
                                end
                                else
                                begin
                                    state_next.phase = PH_RXDATA;
                                    r[1] = mk(OK_ACTION,
                                              (item.data_byte == 8'd1) ? ACT_RX_NACK : ACT_RX_ACK,
                                              8'd0, ST_NONE);
                                    n    = 2'd2;
                                end
                            end
                            PH_RXDATA:
                            begin
                                state_next.bytes_done = done_inc;
                                r[0] = mk(OK_RXBYTE, ACT_START, item.data_byte, ST_NONE);
                                if (done_inc == state.byte_total)
                                begin
                                    r[1] = mk(OK_ACTION, ACT_STOP, 8'd0, ST_NONE);
                                    r[2] = mk(OK_DONE, ACT_START, 8'd0, ST_NONE);
                                    n    = 2'd3;
                                    state_next.phase = PH_IDLE;
                                end
                                else
                                begin
                                    // nack the byte that will be the last one
                                    r[1] = mk(OK_ACTION,
                                              (done_inc2 == {1'b0, state.byte_total}) ?
                                              ACT_RX_NACK : ACT_RX_ACK,
                                              8'd0, ST_NONE);
                                    n    = 2'd2;
                                end
                            end
                            PH_A_RX:
                            begin
                                r[0] = mk(OK_ACTION, ACT_STOP, 8'd0, ST_NONE);
                                r[1] = mk(OK_DONE, ACT_START, {1'b0, item.data_byte[7:1]},
                                          ST_NONE);
                                n    = 2'd2;
                                state_next.phase = PH_IDLE;
                            end
                            default:
                            begin
                                n = 2'd0;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                n = 2'd0;
            end
        endcase

        for (int i = 0; i < MAX_RES; i++)
        begin
            r[i].last = (n == 2'(i + 1));
        end
        res       = r;
        res_count = n;
    end

endmodule

FILE: rtl/core/smbus_master_transaction_sequencer_top.sv
// Channel  | Dir | tdata (low bit up)                                   | tuser    | tlast
// s_axis   | in  | kind, target_addr, first_byte, write_length,         | func     | -
//          |     | data_byte, bus_result, 5 zero bits                   |          |
// m_axis   | out | bus_action, out_byte, status, 2 zero bits            | out_kind | last
// cfg      | in  | cfg_wr_en / cfg_wr_data = alert_response_addr        | -        | -
//
// One input beat is decoded in the cycle it is accepted; its zero to three result beats
// sit in a three-entry result buffer and leave one per cycle from the next cycle on.
// An item with one result allows a new input beat every cycle; an item with n results
// holds s_axis_tready low until only its last result is left.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, empties the buffer
// and sets alert_response_addr to 12.
// A stall on m_axis holds the buffer and, once it is not draining, stalls s_axis.
module smbus_master_transaction_sequencer_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [6:0]                            cfg_wr_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // kind, target_addr, first_byte, write_length, data_byte, bus_result, zero pad
    input  logic [smbms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // func
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // bus_action, out_byte, status, zero pad
    output logic [smbms_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // out_kind
    output logic [2:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast
);
    import smbms_pkg::*;

    logic [6:0] alert_addr_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    in_item_t   item;
    res_vec_t   res;
    logic [1:0] res_count;
    res_vec_t   buf_reg;
    logic [1:0] rd_reg;
    logic [1:0] cnt_reg;
    result_t    head;
    logic       in_fire;
    logic       out_fire;

    assign item.func         = s_axis_tuser;
    assign item.kind         = s_axis_tdata[1:0];
    assign item.target_addr  = s_axis_tdata[8:2];
    assign item.first_byte   = s_axis_tdata[16:9];
    assign item.write_length = s_axis_tdata[24:17];
    assign item.data_byte    = s_axis_tdata[32:25];
    assign item.bus_result   = s_axis_tdata[34:33];

    smbms_step u_step (
        .item       (item),
        .state      (state_reg),
        .alert_addr (alert_addr_reg),
        .state_next (state_next),
        .res        (res),
        .res_count  (res_count)
    );

    // take a new beat once the buffer is empty or its final entry leaves now
    assign s_axis_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;

    assign head          = buf_reg[rd_reg];
    assign m_axis_tdata  = {2'b00, head.status, head.out_byte, head.bus_action};
    assign m_axis_tuser  = head.out_kind;
    assign m_axis_tlast  = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alert_addr_reg <= 7'd12;
        end
        else if (cfg_wr_en)
        begin
            alert_addr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_IDLE;
            state_reg.op_kind       <= 2'd0;
            state_reg.saved_addr    <= 7'd0;
            state_reg.saved_command <= 8'd0;
            state_reg.byte_total    <= 8'd0;
            state_reg.bytes_done    <= 8'd0;
            rd_reg                  <= 2'd0;
            cnt_reg                 <= 2'd0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
            rd_reg    <= 2'd0;
            cnt_reg   <= res_count;
        end
        else if (out_fire)
        begin
            rd_reg  <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            buf_reg <= res;
        end
    end

endmodule

FILE: rtl/core/smbms_checker.sv
module smbms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import smbms_pkg::*;

    logic [2:0] act;
    logic [2:0] st;

    assign act = m_axis_tdata[2:0];
    assign st  = m_axis_tdata[13:11];

    // a status only rides on a done beat
    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && st != ST_NONE) |-> (m_axis_tuser == OK_DONE))
        else $error("status on a non-done beat");

    // a nonzero action code only rides on an action beat
    a_action_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && act != ACT_START) |-> (m_axis_tuser == OK_ACTION))
        else $error("action code on a non-action beat");

    // the beats of one item leave without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside the results of one item");

    // a done beat always closes its item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == OK_DONE) |-> m_axis_tlast)
        else $error("done beat without tlast");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled beat changed");

endmodule

bind smbus_master_transaction_sequencer_top smbms_checker u_smbms_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
